// ----- hdl/dnse_pkg.sv -----
package dnse_pkg;

   localparam int DEF_MAX_NODES = 4096;
   localparam int DEF_MAX_EDGES = 16384;

   localparam int NODE_W   = 13;
   localparam int THRESH_W = 8;
   localparam int AMOUNT_W = 32;
   localparam int SUM_W    = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [NODE_W-1:0]   NODE_COUNT_RESET = 13'd1;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 8'd10;

   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

   typedef enum logic [1:0] {
      OP_ADD_EDGE = 2'd0,
      OP_BUILD    = 2'd1,
      OP_ADD_VAL  = 2'd2,
      OP_QUERY    = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_OK     = 1'b0,
      ST_REJECT = 1'b1
   } status_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic [NODE_W-1:0]           node_u;
      logic [NODE_W-1:0]           node_v;
      logic signed [AMOUNT_W-1:0]  amount;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] neighbour_sum;
      status_type              status;
   } rsp_type;

endpackage

// ----- hdl/degeneracy_neighbor_sum_engine.sv -----
// Degeneracy-orientation neighbour-sum engine. One command beat at a time is taken on req_ and
// exactly one result beat is returned on rsp_. All graph state sits in single-port memories
// walked by one sequencer, which can access several of them at once. After reset a clearing
// pass over every node entry runs before the first command is taken. Add edge reads and writes
// the list heads of both nodes; add and query walk the out-edges of the node (at most the
// threshold after build), and a rejected command goes straight to the result. Build seeds the
// queue from the in-use nodes, peels queued nodes (skipping entries already removed) and walks
// their adjacency, then walks every node and its oriented edges to seed the sums. The engine is
// ready for the next command in the cycle after the result is registered. A result waiting on
// rsp_ does not stop the next command from being taken, but a second result holds the engine
// until the first beat has gone.
module degeneracy_neighbor_sum_engine #(
   parameter int MAX_NODES = dnse_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = dnse_pkg::DEF_MAX_EDGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dnse_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dnse_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [dnse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dnse_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW  = $clog2(MAX_NODES + 1);
   localparam int CW  = $clog2(MAX_NODES + 2);
   localparam int GEW = $clog2(2 * MAX_EDGES + 1);
   localparam int DEW = $clog2(MAX_EDGES + 1);
   localparam int DGW = $clog2(2 * MAX_EDGES + 1);
   localparam int SW  = dnse_pkg::SUM_W;
   localparam int NW  = dnse_pkg::NODE_W;

   typedef struct packed {
      logic [AW-1:0]  to;
      logic [GEW-1:0] nx;
   } glink_type;

   typedef struct packed {
      logic [AW-1:0]  to;
      logic [DEW-1:0] nx;
   } dlink_type;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_DECODE,
      S_E_RDU, S_E_WRU, S_E_RDV, S_E_WRV,
      S_B_SEED_RD, S_B_SEED_CHK, S_B_POP, S_B_POP_D, S_B_REM, S_B_HEAD,
      S_B_EDGE, S_B_EDGE_D, S_B_CHKV, S_B_LINK,
      S_B_SUM_RD, S_B_SUM_HD, S_B_SUM_E, S_B_SUM_ED, S_B_SUM_WR,
      S_A_RD, S_A_WR, S_A_E, S_A_ED, S_A_WR2,
      S_Q_RD, S_Q_HD, S_Q_E, S_Q_ED, S_Q_ACC,
      S_DONE
   } state_type;

   // memories
   logic [DGW-1:0] deg_mem   [MAX_NODES+1];
   logic           rem_mem   [MAX_NODES+1];
   logic [SW-1:0]  val_mem   [MAX_NODES+1];
   logic [SW-1:0]  sum_mem   [MAX_NODES+1];
   logic [GEW-1:0] ghead_mem [MAX_NODES+1];
   logic [DEW-1:0] dhead_mem [MAX_NODES+1];
   glink_type      graph_mem [2*MAX_EDGES+1];
   dlink_type      dag_mem   [MAX_EDGES+1];
   logic [AW-1:0]  queue_mem [MAX_NODES+1];

   logic           deg_we, rem_we, val_we, sum_we, ghead_we, dhead_we, graph_we, dag_we;
   logic           queue_we;
   logic [AW-1:0]  deg_addr, rem_addr, val_addr, sum_addr, ghead_addr, dhead_addr, queue_addr;
   logic [GEW-1:0] graph_addr;
   logic [DEW-1:0] dag_addr;
   logic [DGW-1:0] deg_wd;
   logic           rem_wd;
   logic [SW-1:0]  val_wd, sum_wd;
   logic [GEW-1:0] ghead_wd;
   logic [DEW-1:0] dhead_wd;
   glink_type      graph_wd;
   dlink_type      dag_wd;
   logic [AW-1:0]  queue_wd;

   logic [DGW-1:0] deg_rd_ff;
   logic           rem_rd_ff;
   logic [SW-1:0]  val_rd_ff, sum_rd_ff;
   logic [GEW-1:0] ghead_rd_ff;
   logic [DEW-1:0] dhead_rd_ff;
   glink_type      graph_rd_ff;
   dlink_type      dag_rd_ff;
   logic [AW-1:0]  queue_rd_ff;

   // control and working registers
   state_type                      state_ff;
   dnse_pkg::opcode_type           op_ff;
   logic [NW-1:0]                  u_ff, v_ff;
   logic [SW-1:0]                  amt_ff;
   logic [CW-1:0]                  cnt_ff, qh_ff, qt_ff;
   logic [AW-1:0]                  cur_ff, nb_ff;
   logic [GEW-1:0]                 ge_ff, gu_ff;
   logic [DEW-1:0]                 de_ff, du_ff, et_ff;
   logic [SW-1:0]                  acc_ff, valh_ff;
   logic                           built_ff;
   dnse_pkg::status_type           st_ff;
   logic [NW-1:0]                  ncount_ff;
   logic [dnse_pkg::THRESH_W-1:0]  thr_ff;
   logic                           rsp_valid_ff;
   dnse_pkg::rsp_type              rsp_ff;

   logic [31:0]    active;
   logic           u_ok, v_ok, seed_push, peel_push, dag_room, q_room;
   logic [AW-1:0]  u_node, v_node, cnt_node;
   logic [DGW-1:0] deg_dec;

   assign active   = (32'(ncount_ff) < 32'(MAX_NODES)) ? 32'(ncount_ff) : 32'(MAX_NODES);
   assign u_ok     = (u_ff != '0) && (32'(u_ff) <= active);
   assign v_ok     = (v_ff != '0) && (32'(v_ff) <= active);
   assign u_node   = AW'(u_ff);
   assign v_node   = AW'(v_ff);
   assign cnt_node = cnt_ff[AW-1:0];
   assign q_room   = 32'(qt_ff) <= 32'(MAX_NODES);
   assign dag_room = 32'(du_ff) < 32'(MAX_EDGES);
   assign deg_dec  = (deg_rd_ff == '0) ? '0 : deg_rd_ff - DGW'(1);
   assign seed_push = (32'(deg_rd_ff) <= 32'(thr_ff)) && q_room;
   assign peel_push = (32'(deg_dec) == 32'(thr_ff)) && q_room;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      deg_we = 1'b0;   deg_addr = '0;   deg_wd = '0;
      rem_we = 1'b0;   rem_addr = '0;   rem_wd = 1'b0;
      val_we = 1'b0;   val_addr = '0;   val_wd = '0;
      sum_we = 1'b0;   sum_addr = '0;   sum_wd = '0;
      ghead_we = 1'b0; ghead_addr = '0; ghead_wd = '0;
      dhead_we = 1'b0; dhead_addr = '0; dhead_wd = '0;
      graph_we = 1'b0; graph_addr = '0; graph_wd = '0;
      dag_we = 1'b0;   dag_addr = '0;   dag_wd = '0;
      queue_we = 1'b0; queue_addr = '0; queue_wd = '0;
      case (state_ff)
         S_CLEAR: begin
            deg_we = 1'b1;   deg_addr = cnt_node;
            rem_we = 1'b1;   rem_addr = cnt_node;
            val_we = 1'b1;   val_addr = cnt_node;
            sum_we = 1'b1;   sum_addr = cnt_node;
            ghead_we = 1'b1; ghead_addr = cnt_node;
            dhead_we = 1'b1; dhead_addr = cnt_node;
         end
         S_E_RDU: begin
            ghead_addr = u_node;
            deg_addr = u_node;
         end
         S_E_WRU, S_E_WRV: begin
            graph_we = 1'b1;
            graph_addr = gu_ff + GEW'(1);
            graph_wd.to = (state_ff == S_E_WRU) ? v_node : u_node;
            graph_wd.nx = ghead_rd_ff;
            ghead_we = 1'b1;
            ghead_addr = (state_ff == S_E_WRU) ? u_node : v_node;
            ghead_wd = gu_ff + GEW'(1);
            deg_we = 1'b1;
            deg_addr = ghead_addr;
            deg_wd = deg_rd_ff + DGW'(1);
         end
         S_E_RDV: begin
            ghead_addr = v_node;
            deg_addr = v_node;
         end
         S_B_SEED_RD: deg_addr = cnt_node;
         S_B_SEED_CHK: begin
            queue_we = seed_push;
            queue_addr = qt_ff[AW-1:0];
            queue_wd = cnt_node;
         end
         S_B_POP: queue_addr = qh_ff[AW-1:0];
         S_B_POP_D: rem_addr = queue_rd_ff;
         S_B_REM: begin
            rem_we = !rem_rd_ff;
            rem_addr = cur_ff;
            rem_wd = 1'b1;
            ghead_addr = cur_ff;
         end
         S_B_EDGE: graph_addr = ge_ff;
         S_B_EDGE_D: rem_addr = graph_rd_ff.to;
         S_B_CHKV: begin
            dhead_addr = cur_ff;
            deg_addr = nb_ff;
         end
         S_B_LINK: begin
            dag_we = dag_room;
            dag_addr = du_ff + DEW'(1);
            dag_wd.to = nb_ff;
            dag_wd.nx = dhead_rd_ff;
            dhead_we = dag_room;
            dhead_addr = cur_ff;
            dhead_wd = du_ff + DEW'(1);
            deg_we = 1'b1;
            deg_addr = nb_ff;
            deg_wd = deg_dec;
            queue_we = peel_push;
            queue_addr = qt_ff[AW-1:0];
            queue_wd = nb_ff;
         end
         S_B_SUM_RD: begin
            dhead_addr = cnt_node;
            val_addr = cnt_node;
         end
         S_B_SUM_E, S_A_E, S_Q_E: dag_addr = de_ff;
         S_B_SUM_ED, S_A_ED: sum_addr = dag_rd_ff.to;
         S_B_SUM_WR: begin
            sum_we = 1'b1;
            sum_addr = nb_ff;
            sum_wd = sum_rd_ff + valh_ff;
         end
         S_A_RD: begin
            val_addr = u_node;
            dhead_addr = u_node;
         end
         S_A_WR: begin
            val_we = 1'b1;
            val_addr = u_node;
            val_wd = val_rd_ff + amt_ff;
         end
         S_A_WR2: begin
            sum_we = 1'b1;
            sum_addr = nb_ff;
            sum_wd = sum_rd_ff + amt_ff;
         end
         S_Q_RD: begin
            sum_addr = u_node;
            dhead_addr = u_node;
         end
         S_Q_ED: val_addr = dag_rd_ff.to;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_addr] <= deg_wd;
      deg_rd_ff <= deg_mem[deg_addr];
   end
   always_ff @(posedge clock) begin
      if (rem_we) rem_mem[rem_addr] <= rem_wd;
      rem_rd_ff <= rem_mem[rem_addr];
   end
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_addr] <= val_wd;
      val_rd_ff <= val_mem[val_addr];
   end
   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_addr] <= sum_wd;
      sum_rd_ff <= sum_mem[sum_addr];
   end
   always_ff @(posedge clock) begin
      if (ghead_we) ghead_mem[ghead_addr] <= ghead_wd;
      ghead_rd_ff <= ghead_mem[ghead_addr];
   end
   always_ff @(posedge clock) begin
      if (dhead_we) dhead_mem[dhead_addr] <= dhead_wd;
      dhead_rd_ff <= dhead_mem[dhead_addr];
   end
   always_ff @(posedge clock) begin
      if (graph_we) graph_mem[graph_addr] <= graph_wd;
      graph_rd_ff <= graph_mem[graph_addr];
   end
   always_ff @(posedge clock) begin
      if (dag_we) dag_mem[dag_addr] <= dag_wd;
      dag_rd_ff <= dag_mem[dag_addr];
   end
   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_addr] <= queue_wd;
      queue_rd_ff <= queue_mem[queue_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         gu_ff        <= '0;
         du_ff        <= '0;
         et_ff        <= '0;
         built_ff     <= 1'b0;
         ncount_ff    <= dnse_pkg::NODE_COUNT_RESET;
         thr_ff       <= dnse_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               dnse_pkg::REG_NODE_COUNT: ncount_ff <= csr_wdata;
               dnse_pkg::REG_THRESHOLD:  thr_ff <= csr_wdata[dnse_pkg::THRESH_W-1:0];
               default: ;
            endcase
         end
         // in S_DONE the valid flag is handled with the new result
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_CLEAR: begin
               if (32'(cnt_ff) == 32'(MAX_NODES)) state_ff <= S_IDLE;
               cnt_ff <= cnt_ff + CW'(1);
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff  <= req_data.opcode;
                  u_ff   <= req_data.node_u;
                  v_ff   <= req_data.node_v;
                  amt_ff <= {{(SW-dnse_pkg::AMOUNT_W){req_data.amount[dnse_pkg::AMOUNT_W-1]}},
                             req_data.amount};
                  acc_ff <= '0;
                  st_ff  <= dnse_pkg::ST_OK;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               case (op_ff)
                  dnse_pkg::OP_ADD_EDGE: begin
                     if (built_ff || (32'(et_ff) >= 32'(MAX_EDGES)) || !u_ok || !v_ok) begin
                        st_ff <= dnse_pkg::ST_REJECT;
                        state_ff <= S_DONE;
                     end else state_ff <= S_E_RDU;
                  end
                  dnse_pkg::OP_BUILD: begin
                     if (built_ff) begin
                        st_ff <= dnse_pkg::ST_REJECT;
                        state_ff <= S_DONE;
                     end else begin
                        cnt_ff <= CW'(1);
                        qh_ff <= '0;
                        qt_ff <= '0;
                        state_ff <= S_B_SEED_RD;
                     end
                  end
                  dnse_pkg::OP_ADD_VAL: begin
                     if (!u_ok) begin
                        st_ff <= dnse_pkg::ST_REJECT;
                        state_ff <= S_DONE;
                     end else state_ff <= S_A_RD;
                  end
                  default: begin
                     if (!u_ok) begin
                        st_ff <= dnse_pkg::ST_REJECT;
                        state_ff <= S_DONE;
                     end else state_ff <= S_Q_RD;
                  end
               endcase
            end
            S_E_RDU: state_ff <= S_E_WRU;
            S_E_WRU: begin
               gu_ff <= gu_ff + GEW'(1);
               state_ff <= S_E_RDV;
            end
            S_E_RDV: state_ff <= S_E_WRV;
            S_E_WRV: begin
               gu_ff <= gu_ff + GEW'(1);
               et_ff <= et_ff + DEW'(1);
               state_ff <= S_DONE;
            end
            // seed the peel queue from nodes at or below the threshold
            S_B_SEED_RD: begin
               if (32'(cnt_ff) > active) state_ff <= S_B_POP;
               else state_ff <= S_B_SEED_CHK;
            end
            S_B_SEED_CHK: begin
               if (seed_push) qt_ff <= qt_ff + CW'(1);
               cnt_ff <= cnt_ff + CW'(1);
               state_ff <= S_B_SEED_RD;
            end
            S_B_POP: begin
               if (qh_ff < qt_ff) begin
                  qh_ff <= qh_ff + CW'(1);
                  state_ff <= S_B_POP_D;
               end else begin
                  cnt_ff <= CW'(1);
                  state_ff <= S_B_SUM_RD;
               end
            end
            S_B_POP_D: begin
               cur_ff <= queue_rd_ff;
               state_ff <= S_B_REM;
            end
            S_B_REM: state_ff <= rem_rd_ff ? S_B_POP : S_B_HEAD;
            S_B_HEAD: begin
               ge_ff <= ghead_rd_ff;
               state_ff <= S_B_EDGE;
            end
            S_B_EDGE: state_ff <= (ge_ff == '0) ? S_B_POP : S_B_EDGE_D;
            S_B_EDGE_D: begin
               nb_ff <= graph_rd_ff.to;
               ge_ff <= graph_rd_ff.nx;
               state_ff <= S_B_CHKV;
            end
            S_B_CHKV: state_ff <= rem_rd_ff ? S_B_EDGE : S_B_LINK;
            S_B_LINK: begin
               if (dag_room) du_ff <= du_ff + DEW'(1);
               if (peel_push) qt_ff <= qt_ff + CW'(1);
               state_ff <= S_B_EDGE;
            end
            // push every node's value into the sums of the nodes it points at
            S_B_SUM_RD: state_ff <= S_B_SUM_HD;
            S_B_SUM_HD: begin
               de_ff <= dhead_rd_ff;
               valh_ff <= val_rd_ff;
               state_ff <= S_B_SUM_E;
            end
            S_B_SUM_E: begin
               if (de_ff != '0) state_ff <= S_B_SUM_ED;
               else if (32'(cnt_ff) == 32'(MAX_NODES)) begin
                  built_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
                  state_ff <= S_B_SUM_RD;
               end
            end
            S_B_SUM_ED: begin
               nb_ff <= dag_rd_ff.to;
               de_ff <= dag_rd_ff.nx;
               state_ff <= S_B_SUM_WR;
            end
            S_B_SUM_WR: state_ff <= S_B_SUM_E;
            S_A_RD: state_ff <= S_A_WR;
            S_A_WR: begin
               de_ff <= dhead_rd_ff;
               state_ff <= S_A_E;
            end
            S_A_E: state_ff <= (de_ff == '0) ? S_DONE : S_A_ED;
            S_A_ED: begin
               nb_ff <= dag_rd_ff.to;
               de_ff <= dag_rd_ff.nx;
               state_ff <= S_A_WR2;
            end
            S_A_WR2: state_ff <= S_A_E;
            S_Q_RD: state_ff <= S_Q_HD;
            S_Q_HD: begin
               acc_ff <= sum_rd_ff;
               de_ff <= dhead_rd_ff;
               state_ff <= S_Q_E;
            end
            S_Q_E: state_ff <= (de_ff == '0) ? S_DONE : S_Q_ED;
            S_Q_ED: begin
               de_ff <= dag_rd_ff.nx;
               state_ff <= S_Q_ACC;
            end
            S_Q_ACC: begin
               acc_ff <= acc_ff + val_rd_ff;
               state_ff <= S_Q_E;
            end
            S_DONE: begin
               // result beat waits here until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.neighbour_sum <= acc_ff;
                  rsp_ff.status <= st_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- test/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = dnse_pkg::DEF_MAX_NODES;
   localparam int EDGES = dnse_pkg::DEF_MAX_EDGES;
   localparam int NW    = dnse_pkg::NODE_W;
   localparam int DW    = dnse_pkg::CSR_DATA_W;

   // mirror of the engine: adjacency, peeling and neighbour sums
   class nsum_scoreboard;
      int unsigned node_cnt;
      int unsigned thresh;
      int unsigned deg [NODES+1];
      bit          gone [NODES+1];
      logic [63:0] val [NODES+1];
      logic [63:0] csum [NODES+1];
      int          adj [NODES+1][$];
      int          dag [NODES+1][$];
      int unsigned edge_cnt;
      int unsigned dag_cnt;
      bit          built;
      dnse_pkg::rsp_type sum_q [$];
      int          errors;
      int          n_checked;
      int          n_rejected;
      int          n_queries;

      function new();
         node_cnt = 32'(dnse_pkg::NODE_COUNT_RESET);
         thresh   = 32'(dnse_pkg::THRESHOLD_RESET);
         for (int i = 0; i <= NODES; i++) begin
            deg[i] = 0; gone[i] = 0; val[i] = '0; csum[i] = '0;
         end
      endfunction

      function void set_reg(logic [dnse_pkg::CSR_IDX_W-1:0] idx,
                            logic [dnse_pkg::CSR_DATA_W-1:0] d);
         if (idx == dnse_pkg::REG_NODE_COUNT) node_cnt = 32'(d);
         else thresh = 32'(d[dnse_pkg::THRESH_W-1:0]);
      endfunction

      function int unsigned active_nodes();
         return (node_cnt < NODES) ? node_cnt : NODES;
      endfunction

      function bit node_ok(int unsigned x);
         return x >= 1 && x <= active_nodes();
      endfunction

      function void peel();
         int q [$];
         int qh;
         int u;
         int v;
         qh = 0;
         for (int i = 1; i <= active_nodes(); i++)
            if (deg[i] <= thresh && q.size() <= NODES) q.push_back(i);
         while (qh < q.size()) begin
            u = q[qh++];
            if (gone[u]) continue;
            gone[u] = 1;
            foreach (adj[u][k]) begin
               v = adj[u][k];
               if (gone[v]) continue;
               if (dag_cnt < EDGES) begin
                  dag[u].push_back(v);
                  dag_cnt++;
               end
               if (deg[v] > 0) deg[v]--;
               if (deg[v] == thresh && q.size() <= NODES) q.push_back(v);
            end
         end
         for (int i = 1; i <= NODES; i++)
            foreach (dag[i][k]) csum[dag[i][k]] += val[i];
         built = 1;
      endfunction

      function void note_command(dnse_pkg::req_type c);
         dnse_pkg::rsp_type r;
         logic [63:0] amt;
         int unsigned u;
         int unsigned v;
         u = 32'(c.node_u);
         v = 32'(c.node_v);
         amt = {{32{c.amount[31]}}, c.amount};
         r.neighbour_sum = '0;
         r.status = dnse_pkg::ST_OK;
         case (c.opcode)
            dnse_pkg::OP_ADD_EDGE: begin
               if (built || edge_cnt >= EDGES || !node_ok(u) || !node_ok(v)) begin
                  r.status = dnse_pkg::ST_REJECT;
               end else begin
                  // lists are walked newest first
                  adj[u].push_front(v);
                  adj[v].push_front(u);
                  deg[u]++;
                  deg[v]++;
                  edge_cnt++;
               end
            end
            dnse_pkg::OP_BUILD: begin
               if (built) r.status = dnse_pkg::ST_REJECT;
               else peel();
            end
            dnse_pkg::OP_ADD_VAL: begin
               if (!node_ok(u)) begin
                  r.status = dnse_pkg::ST_REJECT;
               end else begin
                  val[u] += amt;
                  foreach (dag[u][k]) csum[dag[u][k]] += amt;
               end
            end
            default: begin
               if (!node_ok(u)) begin
                  r.status = dnse_pkg::ST_REJECT;
               end else begin
                  r.neighbour_sum = csum[u];
                  foreach (dag[u][k]) r.neighbour_sum += val[dag[u][k]];
                  n_queries++;
               end
            end
         endcase
         if (r.status == dnse_pkg::ST_REJECT) n_rejected++;
         sum_q.push_back(r);
      endfunction

      function void check_result(dnse_pkg::rsp_type a);
         dnse_pkg::rsp_type e;
         n_checked++;
         if (sum_q.size() == 0) begin
            $display("%0t: result with nothing outstanding: sum %h status %0d",
                     $realtime, a.neighbour_sum, a.status);
            errors++;
            return;
         end
         e = sum_q.pop_front();
         if (a.neighbour_sum !== e.neighbour_sum) begin
            $display("%0t: neighbour_sum expected %h actual %h",
                     $realtime, e.neighbour_sum, a.neighbour_sum);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   dnse_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   dnse_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [dnse_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dnse_pkg::CSR_DATA_W-1:0] csr_wdata;

   nsum_scoreboard sb = new();
   int burst_left;
   int rsp_beats;
   int hold_left;
   bit held;
   int stall_pct;
   int stall_phase;
   int graph_n;

   degeneracy_neighbor_sum_engine u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #20ms;
      $display("FAIL degeneracy_neighbor_sum_engine");
      $finish;
   end

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_data);
         rsp_beats++;
      end
   end

   // receiver stalls, with one long hold-off to back the engine up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!held && rsp_beats >= 300) begin
         held = 1;
         hold_left = 500;
         rsp_ready <= 1'b0;
      end else begin
         stall_phase++;
         if (stall_phase % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_cmd(dnse_pkg::opcode_type op, int u, int v, logic [31:0] amt);
      dnse_pkg::req_type c;
      c.opcode = op;
      c.node_u = NW'(u);
      c.node_v = NW'(v);
      c.amount = amt;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
      sb.note_command(c);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.sum_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [dnse_pkg::CSR_IDX_W-1:0] idx, int d);
      logic [dnse_pkg::CSR_DATA_W-1:0] wd;
      wd = DW'(d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wd;
      @(posedge clock);
      sb.set_reg(idx, wd);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_node();
      return $urandom_range(1, graph_n);
   endfunction

   // mostly edges among the in-use nodes, some values and lookups, some noise
   task automatic random_prebuild(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60)
            send_cmd(dnse_pkg::OP_ADD_EDGE, pick_node(), pick_node(), $urandom);
         else if (r < 75)
            send_cmd(dnse_pkg::OP_ADD_VAL, pick_node(), $urandom_range(0, 8191), $urandom);
         else if (r < 85)
            send_cmd(dnse_pkg::OP_QUERY, pick_node(), $urandom_range(0, 8191), $urandom);
         else
            send_cmd(dnse_pkg::opcode_type'($urandom_range(0, 1) ? dnse_pkg::OP_ADD_EDGE :
                        ($urandom_range(0, 1) ? dnse_pkg::OP_ADD_VAL : dnse_pkg::OP_QUERY)),
                     $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom);
      end
   endtask

   task automatic random_postbuild(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            send_cmd(dnse_pkg::OP_ADD_VAL, pick_node(), $urandom_range(0, 8191), $urandom);
         else if (r < 90)
            send_cmd(dnse_pkg::OP_QUERY, pick_node(), $urandom_range(0, 8191), $urandom);
         else
            send_cmd(dnse_pkg::opcode_type'($urandom_range(0, 3)), $urandom_range(0, 8191),
                     $urandom_range(0, 8191), $urandom);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      burst_left = 0;
      stall_pct = 0;
      graph_n = 64;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single node in use after reset
      send_cmd(dnse_pkg::OP_QUERY, 1, 0, 0);
      send_cmd(dnse_pkg::OP_ADD_VAL, 1, 0, 32'h7fff_ffff);
      send_cmd(dnse_pkg::OP_ADD_VAL, 1, 0, 32'h8000_0000);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 1, 1, 0);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 0, 1, 0);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 1, 2, 0);
      send_cmd(dnse_pkg::OP_QUERY, 8191, 8191, 32'hffff_ffff);
      send_cmd(dnse_pkg::OP_ADD_VAL, 0, 0, 5);
      wait_drained();

      write_reg(dnse_pkg::REG_NODE_COUNT, NODES);
      write_reg(dnse_pkg::REG_THRESHOLD, 255);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 4096, 1, 0);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 4096, 4096, 0);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 4097, 1, 0);
      send_cmd(dnse_pkg::OP_ADD_VAL, 4096, 0, 32'hffff_ffff);
      send_cmd(dnse_pkg::OP_QUERY, 4096, 0, 0);
      wait_drained();

      write_reg(dnse_pkg::REG_THRESHOLD, 0);
      write_reg(dnse_pkg::REG_NODE_COUNT, graph_n);
      random_prebuild(260);
      wait_drained();

      // count shrunk after edges went in; the peel still follows them
      write_reg(dnse_pkg::REG_NODE_COUNT, 48);
      write_reg(dnse_pkg::REG_THRESHOLD, $urandom_range(3, 6));
      send_cmd(dnse_pkg::OP_BUILD, 0, 0, 0);
      send_cmd(dnse_pkg::OP_BUILD, 0, 0, 0);
      send_cmd(dnse_pkg::OP_ADD_EDGE, 1, 2, 0);
      send_cmd(dnse_pkg::OP_QUERY, 1, 0, 0);
      send_cmd(dnse_pkg::OP_QUERY, 60, 0, 0);
      wait_drained();

      write_reg(dnse_pkg::REG_NODE_COUNT, graph_n);
      random_postbuild(470);
      send_cmd(dnse_pkg::OP_QUERY, 4096, 0, 0);
      wait_drained();

      $display("covered %0d result beats: %0d queries answered, %0d commands rejected",
               sb.n_checked, sb.n_queries, sb.n_rejected);
      $display("graph of %0d edges peeled into %0d oriented edges", sb.edge_cnt, sb.dag_cnt);
      if (sb.errors == 0)
         $display("PASS degeneracy_neighbor_sum_engine");
      else
         $display("FAIL degeneracy_neighbor_sum_engine");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/dnse_pkg.sv
hdl/degeneracy_neighbor_sum_engine.sv
test/tb.sv
